@@ hw/rtl/srrw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW_SLOTS = 16;
  localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  localparam int NUM_W  = 24;             // datagram numbers and byte offsets
  localparam int LEN_W  = 16;             // datagram length
  localparam int OFF_W  = NUM_W + LEN_W;  // full product number * size
  localparam int TICK_W = 32;

  localparam logic [15:0] DGRAM_RST   = 16'd1000;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // configuration register indexes
  localparam logic [1:0] CFG_TOTAL   = 2'd0;
  localparam logic [1:0] CFG_DGRAM   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    SLOT_IDLE  = 2'd0,
    SLOT_REQ   = 2'd1,
    SLOT_ACKED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_DLV  = 2'd1,
    KIND_STAT = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_MUL,
    ST_FILL,
    ST_TO_MUL,
    ST_TO_RD,
    ST_TO_CHK,
    ST_REL_MUL,
    ST_REL_RD,
    ST_REL_CHK,
    ST_STAT,
    ST_ACK_MUL,
    ST_ACK_WALK
  } state_t;

  // circular slot pointer step
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

@@ hw/rtl/srrw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srrw_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/selective_repeat_receive_window_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit
// Receive-side window of a selective-repeat download: requests, resends and
// in-order release of datagrams, driven by tick and ack beats.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per event. in_mode 0 is a tick, 1 an ack carrying the
//            byte offset of a received datagram.
//   out_*  : result beats. A tick yields request beats (new fills, then
//            resends), deliver beats for slots released in order, and one
//            status beat with out_last set. An ack yields no beat.
//   cfg_*  : register writes; write only while the block is idle and no
//            result beat is pending.
// Sequence: a tick runs the new requests, the timeout scan over the open
//   window, the in-order releases and the status beat, in that order;
//   release stops at the first slot not yet acknowledged. Each scan step
//   reads a slot and then checks it, since the slot memories have
//   registered read data. An ack walks the window one datagram a cycle from
//   its start offset; in_ready is high only between items.
// Reset: window empty, tick counter zero, registers at their defaults. The
//   slot memories are not cleared; only slots inside the window are read and
//   each of them was written when it was filled.
// Stall: a one-beat output register holds the result; the sequencer waits
//   in place at a beat while that register is full and out_ready is low.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit
  import srrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [NUM_W-1:0]  in_ack_offset,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [NUM_W-1:0]  out_byte_offset,
  output logic [LEN_W-1:0]  out_byte_length,
  output logic              out_done_res,
  output logic              out_last,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [NUM_W-1:0]  cfg_wdata
);

  // config registers
  logic [NUM_W-1:0]  total_r;
  logic [LEN_W-1:0]  dgram_r;
  logic [LEN_W-1:0]  timeout_r;

  // control state
  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  begin_r, begin_nxt;
  logic [NUM_W-1:0]  end_r, end_nxt;
  logic [SLOT_W-1:0] begin_slot_r, begin_slot_nxt;
  logic [SLOT_W-1:0] end_slot_r, end_slot_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  // working registers (no reset)
  logic [OFF_W-1:0]  off_r, off_nxt;       // byte offset of the cursor datagram
  logic [NUM_W-1:0]  idx_r, idx_nxt;       // scan cursor datagram number
  logic [SLOT_W-1:0] idx_slot_r, idx_slot_nxt;
  logic [NUM_W-1:0]  ack_off_r, ack_off_nxt;

  // output register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [NUM_W-1:0]  out_off_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_done_r;
  logic              out_last_r;

  // emit request from the sequencer
  logic              emit;
  kind_t             emit_kind;
  logic [NUM_W-1:0]  emit_off;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_done;
  logic              emit_last;
  logic              emit_ok;

  // slot memories
  logic              st_we, tk_we;
  logic [SLOT_W-1:0] st_waddr, tk_waddr, rd_addr;
  logic [1:0]        st_wdata, st_rdata;
  logic [TICK_W-1:0] tk_wdata, tk_rdata;

  // datapath
  logic [LEN_W-1:0]  dsize;
  logic [NUM_W-1:0]  mul_a;
  logic [OFF_W-1:0]  prod;
  logic [OFF_W-1:0]  total_w;
  logic [OFF_W-1:0]  remain;
  logic [OFF_W-1:0]  off_step;
  logic              past_total;
  logic [LEN_W-1:0]  cur_len;
  logic [NUM_W-1:0]  got_bytes;
  logic [NUM_W-1:0]  occupancy;
  logic [TICK_W-1:0] age;
  logic [OFF_W-1:0]  ack_w;
  logic              in_fire;

  srrw_ram #(.WIDTH(2), .DEPTH(WINDOW_SLOTS)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  srrw_ram #(.WIDTH(TICK_W), .DEPTH(WINDOW_SLOTS)) u_tick_ram (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tk_waddr),
    .wdata (tk_wdata),
    .raddr (rd_addr),
    .rdata (tk_rdata)
  );

  // a zero datagram size counts as one byte
  assign dsize = (dgram_r == '0) ? LEN_W'(1) : dgram_r;

  // one multiplier: datagram number times size, registered into off_r
  assign mul_a = (state_r == ST_FILL_MUL) ? end_r : begin_r;
  assign prod  = OFF_W'(mul_a) * OFF_W'(dsize);

  // length of the datagram at off_r, and bytes delivered so far
  assign total_w    = OFF_W'(total_r);
  assign past_total = (off_r >= total_w);
  assign remain     = total_w - off_r;
  assign cur_len    = past_total ? '0 :
                      (remain < OFF_W'(dsize)) ? remain[LEN_W-1:0] : dsize;
  assign got_bytes  = past_total ? total_r : off_r[NUM_W-1:0];
  assign off_step   = off_r + OFF_W'(dsize);

  assign occupancy = end_r - begin_r;
  assign age       = tick_r - tk_rdata;
  assign ack_w     = OFF_W'(ack_off_r);

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit_ok  = !out_valid_r || out_ready;

  // next state and outputs of the sequencer
  always_comb begin
    state_nxt      = state_r;
    begin_nxt      = begin_r;
    end_nxt        = end_r;
    begin_slot_nxt = begin_slot_r;
    end_slot_nxt   = end_slot_r;
    tick_nxt       = tick_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    idx_slot_nxt   = idx_slot_r;
    ack_off_nxt    = ack_off_r;

    emit      = 1'b0;
    emit_kind = KIND_REQ;
    emit_off  = off_r[NUM_W-1:0];
    emit_len  = cur_len;
    emit_done = 1'b0;
    emit_last = 1'b0;

    st_we    = 1'b0;
    st_waddr = idx_slot_r;
    st_wdata = SLOT_IDLE;
    tk_we    = 1'b0;
    tk_waddr = idx_slot_r;
    tk_wdata = tick_r;
    rd_addr  = idx_slot_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode) begin
            ack_off_nxt = in_ack_offset;
            state_nxt   = ST_ACK_MUL;
          end else begin
            tick_nxt  = tick_r + 1'b1;
            state_nxt = ST_FILL_MUL;
          end
        end
      end

      ST_FILL_MUL: begin
        off_nxt   = prod;
        state_nxt = ST_FILL;
      end

      // new requests at the window end
      ST_FILL: begin
        if (occupancy < NUM_W'(WINDOW_SLOTS - 1) && !past_total) begin
          if (emit_ok) begin
            emit         = 1'b1;
            st_we        = 1'b1;
            st_waddr     = end_slot_r;
            st_wdata     = SLOT_REQ;
            tk_we        = 1'b1;
            tk_waddr     = end_slot_r;
            end_nxt      = end_r + 1'b1;
            end_slot_nxt = slot_inc(end_slot_r);
            off_nxt      = off_step;
          end
        end else begin
          state_nxt = ST_TO_MUL;
        end
      end

      ST_TO_MUL: begin
        off_nxt      = prod;
        idx_nxt      = begin_r;
        idx_slot_nxt = begin_slot_r;
        state_nxt    = ST_TO_RD;
      end

      // timeout scan, one slot per read
      ST_TO_RD: begin
        state_nxt = (idx_r == end_r) ? ST_REL_MUL : ST_TO_CHK;
      end

      ST_TO_CHK: begin
        if (st_rdata == SLOT_REQ && age > TICK_W'(timeout_r)) begin
          if (emit_ok) begin
            emit         = 1'b1;
            tk_we        = 1'b1;
            idx_nxt      = idx_r + 1'b1;
            idx_slot_nxt = slot_inc(idx_slot_r);
            off_nxt      = off_step;
            state_nxt    = ST_TO_RD;
          end
        end else begin
          idx_nxt      = idx_r + 1'b1;
          idx_slot_nxt = slot_inc(idx_slot_r);
          off_nxt      = off_step;
          state_nxt    = ST_TO_RD;
        end
      end

      ST_REL_MUL: begin
        off_nxt   = prod;
        state_nxt = ST_REL_RD;
      end

      // in-order release from the window start
      ST_REL_RD: begin
        rd_addr   = begin_slot_r;
        state_nxt = (begin_r == end_r) ? ST_STAT : ST_REL_CHK;
      end

      ST_REL_CHK: begin
        rd_addr = begin_slot_r;
        if (st_rdata == SLOT_ACKED) begin
          if (emit_ok) begin
            emit           = 1'b1;
            emit_kind      = KIND_DLV;
            st_we          = 1'b1;
            st_waddr       = begin_slot_r;
            st_wdata       = SLOT_IDLE;
            begin_nxt      = begin_r + 1'b1;
            begin_slot_nxt = slot_inc(begin_slot_r);
            off_nxt        = off_step;
            state_nxt      = ST_REL_RD;
          end
        end else begin
          state_nxt = ST_STAT;
        end
      end

      // off_r is begin * size here
      ST_STAT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_kind = KIND_STAT;
          emit_off  = got_bytes;
          emit_len  = '0;
          emit_done = past_total;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_ACK_MUL: begin
        off_nxt      = prod;
        idx_nxt      = begin_r;
        idx_slot_nxt = begin_slot_r;
        state_nxt    = ST_ACK_WALK;
      end

      // walk the window until the acked offset falls into a datagram
      ST_ACK_WALK: begin
        if (idx_r == end_r || ack_w < off_r) begin
          state_nxt = ST_IDLE;
        end else if (ack_w < off_step) begin
          st_we     = 1'b1;
          st_wdata  = SLOT_ACKED;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt      = idx_r + 1'b1;
          idx_slot_nxt = slot_inc(idx_slot_r);
          off_nxt      = off_step;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      begin_r      <= '0;
      end_r        <= '0;
      begin_slot_r <= '0;
      end_slot_r   <= '0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
      total_r      <= '0;
      dgram_r      <= DGRAM_RST;
      timeout_r    <= TIMEOUT_RST;
    end else begin
      state_r      <= state_nxt;
      begin_r      <= begin_nxt;
      end_r        <= end_nxt;
      begin_slot_r <= begin_slot_nxt;
      end_slot_r   <= end_slot_nxt;
      tick_r       <= tick_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL:   total_r   <= cfg_wdata;
          CFG_DGRAM:   dgram_r   <= cfg_wdata[LEN_W-1:0];
          CFG_TIMEOUT: timeout_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    idx_r      <= idx_nxt;
    idx_slot_r <= idx_slot_nxt;
    ack_off_r  <= ack_off_nxt;
    if (emit) begin
      out_kind_r <= emit_kind;
      out_off_r  <= emit_off;
      out_len_r  <= emit_len;
      out_done_r <= emit_done;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte_offset = out_off_r;
  assign out_byte_length = out_len_r;
  assign out_done_res    = out_done_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // window never holds more than WINDOW_SLOTS-1 datagrams
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (begin_r <= end_r) && (occupancy <= NUM_W'(WINDOW_SLOTS - 1)))
    else $error("window bounds violated");

  // window start only moves forward
  a_begin_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (begin_r >= $past(begin_r)))
    else $error("window start moved back");

  // time advances by one on each tick and only then
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_mode) |=> (tick_r == $past(tick_r) + 1'b1))
    else $error("tick counter step wrong");

  // the final beat of a run is the status beat
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_STAT)))
    else $error("last flag and status kind disagree");

  // a slot pointer tracks its datagram number modulo the window size
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (begin_r == end_r) |-> (begin_slot_r == end_slot_r))
    else $error("slot pointers out of step");
`endif

endmodule

@@ verif/selective_repeat_receive_window_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit_tb
// Self-checking bench for the selective-repeat receive window. Tick and ack
// beats go in under random idling and back-pressure. A window predictor in a
// small scoreboard class works out every request, resend, deliver and status
// beat. Each result beat is checked field by field against the oldest
// expectation.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit_tb;
  import srrw_pkg::*;

  localparam int SETTLE       = 40;        // covers an ack walk still running
  localparam int TAIL         = 100;       // quiet cycles after the last beat
  localparam int HOLD_LEN     = 300;       // long receiver hold-off
  localparam int RANDOM_ITEMS = 400;
  localparam int LIMIT        = 1_500_000; // watchdog, in cycles

  // One expected result beat
  typedef struct {
    kind_t             kind;
    logic [NUM_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              done;
    logic              last;
  } window_beat_t;

  // --------------------------------------------------------------------------
  // Window predictor and expected-beat store
  // --------------------------------------------------------------------------
  class rx_window_model;
    longint unsigned  total_len, dg_size, max_age;
    longint unsigned  first_open, next_new;   // datagram numbers
    slot_st_t         slot_state [WINDOW_SLOTS];
    bit [31:0]        slot_tick [WINDOW_SLOTS];
    bit [31:0]        tick_count;
    window_beat_t     expected_beats [$];
    int errors, n_ticks, n_acks, n_ignored, n_fill, n_resend, n_deliver, n_done;

    function new();
      total_len  = 0;
      dg_size    = DGRAM_RST;
      max_age    = TIMEOUT_RST;
      first_open = 0;
      next_new   = 0;
      tick_count = 0;
      foreach (slot_state[i]) begin
        slot_state[i] = SLOT_IDLE;
        slot_tick[i]  = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [NUM_W-1:0] val);
      case (idx)
        CFG_TOTAL:   total_len = val;
        CFG_DGRAM:   dg_size   = val[15:0];
        CFG_TIMEOUT: max_age   = val[15:0];
        default: ;
      endcase
    endfunction

    // a zero datagram size behaves as one byte
    function longint unsigned dg_eff();
      return (dg_size == 0) ? 1 : dg_size;
    endfunction

    function longint unsigned dg_count();
      return (total_len + dg_eff() - 1) / dg_eff();
    endfunction

    function longint unsigned dg_len(longint unsigned n);
      longint unsigned off;
      off = n * dg_eff();
      if (off >= total_len) return 0;
      return (total_len - off < dg_eff()) ? total_len - off : dg_eff();
    endfunction

    function bit finished();
      return first_open >= dg_count();
    endfunction

    function bit covers(logic [NUM_W-1:0] off);
      longint unsigned n;
      n = off / dg_eff();
      return (n >= first_open) && (n < next_new);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void post(kind_t k, longint unsigned off, longint unsigned len,
                       bit done, bit last);
      window_beat_t b;
      b.kind   = k;
      b.offset = NUM_W'(off);
      b.length = LEN_W'(len);
      b.done   = done;
      b.last   = last;
      expected_beats.push_back(b);
    endfunction

    function void note_event(bit mode, logic [NUM_W-1:0] off);
      int              s;
      bit [31:0]       age;
      longint unsigned cnt, d, got;
      d = dg_eff();
      if (mode) begin
        n_acks++;
        if (covers(off)) slot_state[int'((off / d) % WINDOW_SLOTS)] = SLOT_ACKED;
        else n_ignored++;
        return;
      end
      n_ticks++;
      tick_count++;
      cnt = dg_count();
      // new requests until the window is full or the file is covered
      while (next_new - first_open < WINDOW_SLOTS - 1 && next_new < cnt) begin
        s = int'(next_new % WINDOW_SLOTS);
        slot_state[s] = SLOT_REQ;
        slot_tick[s]  = tick_count;
        post(KIND_REQ, next_new * d, dg_len(next_new), 0, 0);
        n_fill++;
        next_new++;
      end
      // resends: age strictly above the timeout, modulo 2^32
      for (longint unsigned n = first_open; n < next_new; n++) begin
        s = int'(n % WINDOW_SLOTS);
        if (slot_state[s] == SLOT_REQ) begin
          age = tick_count - slot_tick[s];
          if (age > max_age) begin
            slot_tick[s] = tick_count;
            post(KIND_REQ, n * d, dg_len(n), 0, 0);
            n_resend++;
          end
        end
      end
      // in-order release
      while (first_open < next_new &&
             slot_state[int'(first_open % WINDOW_SLOTS)] == SLOT_ACKED) begin
        slot_state[int'(first_open % WINDOW_SLOTS)] = SLOT_IDLE;
        post(KIND_DLV, first_open * d, dg_len(first_open), 0, 0);
        n_deliver++;
        first_open++;
      end
      got = first_open * d;
      if (got > total_len) got = total_len;
      if (first_open >= cnt) n_done++;
      post(KIND_STAT, got, 0, first_open >= cnt, 1);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [NUM_W-1:0] offset,
                             logic [LEN_W-1:0] length, logic done, logic last);
      window_beat_t b;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: beat with nothing expected, expected none, actual kind %0d off %0h",
                   $time, kind, offset);
        return;
      end
      b = expected_beats.pop_front();
      cmp_field("kind", b.kind, kind);
      cmp_field("byte_offset", b.offset, offset);
      cmp_field("byte_length", b.length, length);
      cmp_field("done_res", b.done, done);
      cmp_field("last", b.last, last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              in_mode       = 1'b0;
  logic [NUM_W-1:0]  in_ack_offset = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [1:0]        out_kind;
  logic [NUM_W-1:0]  out_byte_offset;
  logic [LEN_W-1:0]  out_byte_length;
  logic              out_done_res;
  logic              out_last;
  logic              cfg_we        = 1'b0;
  logic [1:0]        cfg_index     = '0;
  logic [NUM_W-1:0]  cfg_wdata     = '0;

  rx_window_model rx_window = new();

  int idle_pct      = 0;   // sender: chance of a gap before a beat
  int stall_pct     = 0;   // receiver: chance of ready low in a cycle
  int hold_requests = 0;   // bumped by the stimulus to ask for a long hold-off
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;   // every accepted input beat
  int cycle_count   = 0;
  bit hold_done     = 1'b0;

  selective_repeat_receive_window_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_ack_offset   (in_ack_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte_offset (out_byte_offset),
    .out_byte_length (out_byte_length),
    .out_done_res    (out_done_res),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request. During the
  // hold the output register stays full, so the sequencer stops and in_ready
  // stays low while the sender keeps offering ticks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor: sampled at the edge, before the DUT updates its outputs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      rx_window.check_beat(out_kind, out_byte_offset, out_byte_length,
                           out_done_res, out_last);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, rx_window.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One input beat. valid is left high after acceptance so that a following
  // beat goes out back to back; anything that pauses must drop it first.
  task automatic push_event(bit mode, logic [NUM_W-1:0] off);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(1, 6)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_ack_offset <= off;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    rx_window.note_event(mode, off);
  endtask

  task automatic tick();
    push_event(1'b0, NUM_W'($urandom));
  endtask

  task automatic ack(logic [NUM_W-1:0] off);
    push_event(1'b1, off);
  endtask

  // Sender goes quiet until every expected beat is back, then waits a while
  // longer since an ack walk has no beat to show it is still running.
  task automatic wait_drained(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rx_window.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Single register write; the 16-bit registers get junk in the upper bits.
  task automatic write_reg(logic [1:0] idx, logic [NUM_W-1:0] val);
    logic [NUM_W-1:0] data;
    data = val;
    if (idx != CFG_TOTAL) data[NUM_W-1:16] = (NUM_W-16)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    rx_window.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(longint unsigned total, longint unsigned dg,
                           longint unsigned tmo);
    wait_drained(SETTLE);
    write_reg(CFG_TOTAL, NUM_W'(total));
    write_reg(CFG_DGRAM, NUM_W'(dg));
    write_reg(CFG_TIMEOUT, NUM_W'(tmo));
  endtask

  // One download: a fresh target a few dozen datagrams past the current
  // window start, then mostly acks of open slots mixed with ticks and noise.
  task automatic run_session(int phase);
    int               goal, r;
    longint unsigned  d, tb, span, n, base;
    logic [NUM_W-1:0] off;
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 67; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 67; end
      default: begin idle_pct = 24; stall_pct = 24; end
    endcase

    if ($urandom_range(9) == 0) begin
      // rare: any size at all, including a zero datagram size
      configure($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 16'hFFFF),
                $urandom_range(1, 16'hFFFF));
    end else begin
      d  = $urandom_range(1, 2000);
      tb = (rx_window.first_open + $urandom_range(1, 40)) * d - $urandom_range(0, d - 1);
      if (tb > 24'hFFFFFF) tb = 24'hFFFFFF;
      configure(tb, d, ($urandom_range(3) == 0) ? $urandom_range(13, 16'hFFFF)
                                                : $urandom_range(1, 12));
    end

    // Long receiver hold-off while ticks keep coming
    if ((phase % 4) == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_requests++;
      repeat (12) tick();
    end

    goal = items_sent + $urandom_range(20, 50);
    while (items_sent < goal) begin
      if (rx_window.finished()) begin
        tick();
        break;
      end
      r = $urandom_range(99);
      d = rx_window.dg_eff();
      if (r < 3) begin
        wait_drained(0);
      end else if (r < 6) begin
        // retarget mid-run, possibly below the open window
        wait_drained(SETTLE);
        tb = (rx_window.next_new + $urandom_range(0, 12)) * d;
        if (tb >= d) tb -= $urandom_range(0, d - 1);
        if (tb > 24'hFFFFFF) tb = 24'hFFFFFF;
        write_reg(CFG_TOTAL, NUM_W'(tb));
        if (r == 5) write_reg(CFG_DGRAM, NUM_W'($urandom_range(1, 2000)));
      end else if (r < 50 && rx_window.next_new > rx_window.first_open) begin
        // ack of an open slot, oldest ones favored so the window drains
        span = rx_window.next_new - rx_window.first_open;
        if ($urandom_range(1) == 0 && span > 4) span = 4;
        n    = rx_window.first_open + $urandom_range(0, span - 1);
        base = n * d;
        if (base > 24'hFFFFFF) begin
          ack(NUM_W'($urandom));
        end else begin
          off = NUM_W'(base);
          if (base + d - 1 <= 24'hFFFFFF) off = NUM_W'(base + $urandom_range(0, d - 1));
          ack(off);
        end
      end else if (r < 85) begin
        tick();
      end else begin
        ack(NUM_W'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int start, phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: empty file, so a tick gives a done status at once
    tick();

    // Three datagrams with a short last one; the middle one acked early and
    // twice, two acks beyond the window; a timeout of two ticks forces resends
    // of the two silent ones, then all three come out in order.
    configure(2500, 1000, 2);
    tick();
    ack(24'd1500);
    ack(24'd1999);
    ack(24'd5000);
    ack(24'hFFFFFF);
    tick();
    tick();
    tick();
    ack(24'd0);
    ack(24'd2000);
    tick();
    tick();                      // finished: status only

    // Zero datagram size counts as one byte; the window fills all the way
    configure(20, 0, 16'hFFFF);
    tick();
    ack(24'd3);
    ack(24'd4);
    ack(24'd17);
    ack(24'd0);                  // below the window
    tick();

    // Largest file and datagram, shortest timeout
    configure(24'hFFFFFF, 16'hFFFF, 1);
    tick();
    ack(NUM_W'(5 * 65535));
    tick();

    // File shrinks under an open window: resends with zero length, done
    wait_drained(SETTLE);
    write_reg(CFG_TOTAL, 24'd1000);
    tick();
    tick();

    // Random downloads, cycling through the idling phases
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      run_session(phase);
      phase++;
    end

    wait_drained(TAIL);
    $display("Ran %0d ticks and %0d acks (%0d outside the window) over %0d downloads",
             rx_window.n_ticks, rx_window.n_acks, rx_window.n_ignored, phase);
    $display("Saw %0d new requests, %0d resends, %0d delivers, %0d done statuses",
             rx_window.n_fill, rx_window.n_resend, rx_window.n_deliver, rx_window.n_done);
    if (rx_window.errors == 0 && rx_window.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
